@@ src/ostb_pkg.sv @@
package ostb_pkg;

   localparam int TIMER_W  = 4;
   localparam int PERIOD_W = 32;
   localparam int TICK_W   = 16;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   typedef struct packed {
      logic                func;
      logic [TIMER_W-1:0]  timer_index;
      logic [PERIOD_W-1:0] period_ms;
      logic [TICK_W-1:0]   tick_ms;
   } req_type;

   typedef struct packed {
      logic [TIMER_W-1:0] expired_timer;
      logic               last_expiry;
   } rsp_type;

   // per-cycle controls broadcast to every cell
   typedef struct packed {
      logic                advance;
      logic [TICK_W-1:0]   tick_ms;
      logic [PERIOD_W-1:0] period_ms;
   } cell_ctl_type;

endpackage

@@ src/ostb_cell.sv @@
module ostb_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  ostb_pkg::cell_ctl_type ctl,
   input  logic                 load,
   input  logic                 token_in,
   output logic                 token_out,
   output logic                 hit
);
   import ostb_pkg::*;

   logic                running_ff, running_in;
   logic                token_ff, token_in_nx;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic [PERIOD_W:0]   sum;
   logic [PERIOD_W-1:0] sat_sum;
   logic                step;

   assign sum     = {1'b0, elapsed_ff} + {{(PERIOD_W + 1 - TICK_W){1'b0}}, ctl.tick_ms};
   assign sat_sum = sum[PERIOD_W] ? {PERIOD_W{1'b1}} : sum[PERIOD_W-1:0];
   assign step    = ctl.advance && token_ff && running_ff;
   assign hit     = token_ff && running_ff && (sat_sum >= period_ff);
   assign token_out = token_ff;

   always_comb begin
      running_in  = running_ff;
      period_in   = period_ff;
      elapsed_in  = elapsed_ff;
      token_in_nx = ctl.advance ? token_in : token_ff;
      if (load) begin
         running_in = 1'b1;
         period_in  = ctl.period_ms;
         elapsed_in = '0;
      end else if (step) begin
         elapsed_in = sat_sum;
         if (hit) begin
            running_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         token_ff   <= 1'b0;
      end else begin
         running_ff <= running_in;
         token_ff   <= token_in_nx;
      end
      period_ff  <= period_in;
      elapsed_ff <= elapsed_in;
   end

endmodule

@@ src/one_shot_timer_bank.sv @@
// start item: accepted while the block is idle, no result
// tick item: a token walks the row of timer cells, one cell per cycle unless the walk
//   is stalled, and the block takes no new item until the walk and its flush are done
// each expiry is held until the next expiry is found or the walk ends, then goes to the
//   result register; a held expiry with a full, stalled result register stalls the walk
// reset (synchronous) disarms every timer and empties the result register
module one_shot_timer_bank #(
   parameter int NUM_TIMERS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ostb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ostb_pkg::rsp_type rsp_data
);
   import ostb_pkg::*;

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [IW-1:0]      walk_idx_ff, walk_idx_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [TIMER_W-1:0] pend_idx_ff, pend_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept, launch, start, out_free, advance, step, hit_any, push;
   rsp_type            push_data;
   cell_ctl_type       ctl;
   logic [NUM_TIMERS:0]   token;
   logic [NUM_TIMERS-1:0] hit_vec;
   logic [NUM_TIMERS-1:0] load_vec;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign launch    = accept && (req_data.func == FUNC_TICK);
   assign start     = accept && (req_data.func == FUNC_START);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit_any   = |hit_vec;
   // the walk holds while a second expiry has nowhere to go
   assign advance   = launch ||
                      ((state_ff == ST_WALK) && !(hit_any && pend_valid_ff && !out_free));
   assign step      = (state_ff == ST_WALK) && advance;

   assign ctl.advance   = advance;
   assign ctl.tick_ms   = tick_ff;
   assign ctl.period_ms = req_data.period_ms;

   assign token[0] = launch;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      assign load_vec[i] = start && (int'(req_data.timer_index) == i);
      ostb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .load      (load_vec[i]),
         .token_in  (token[i]),
         .token_out (token[i+1]),
         .hit       (hit_vec[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      walk_idx_in   = walk_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      push          = 1'b0;
      push_data     = '{expired_timer: pend_idx_ff, last_expiry: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (launch) begin
               tick_in     = req_data.tick_ms;
               walk_idx_in = '0;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            if (step) begin
               walk_idx_in = walk_idx_ff + IW'(1);
               if (hit_any) begin
                  // hold one expiry back so the final one can be marked
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_idx_in   = TIMER_W'(walk_idx_ff);
               end
               if (token[NUM_TIMERS]) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push                  = 1'b1;
               push_data.last_expiry = 1'b1;
               pend_valid_in         = 1'b0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = push || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = push ? push_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      tick_ff     <= tick_in;
      walk_idx_ff <= walk_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_token_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token[NUM_TIMERS:1]))
      else $error("more than one cell holds the walk token");

   a_token_walk_only: assert property (@(posedge clock) disable iff (reset)
      (|token[NUM_TIMERS:1]) |-> (state_ff == ST_WALK))
      else $error("walk token present outside a tick walk");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held expiry left behind after a tick");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_valid_ff) |-> !rsp_stall)
      else $error("expiry pushed over a stalled result");

endmodule
